// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the neighbor counter.
// Standalone header with no dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the expression in the same cycle.
`define ASSERT_NOW(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

// The condition implies the expression in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/ucnt_pkg.sv
// Package of the neighbor counter: sizes, request codes and the ID type.
// No dependencies; used by every module of the block.
package ucnt_pkg;

  localparam int MaxEntries = 16;
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int PeriodW = 16;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd4005;

  localparam logic ReqAdd  = 1'b0;
  localparam logic ReqTick = 1'b1;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
  } id_t;

  typedef struct packed {
    logic report;
  } tmr_stat_t;

endpackage

// File: rtl/core/ucnt_cell.sv
// One cell of the ID chain: holds one stored ID and compares it with the probe.
// Depends on ucnt_pkg for the ID type.
module ucnt_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  logic          occupied,
  input  ucnt_pkg::id_t prev_id,
  input  ucnt_pkg::id_t probe_id,
  output ucnt_pkg::id_t entry_id,
  output logic          match
);

  ucnt_pkg::id_t entry_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= prev_id;
    end
  end

  assign entry_id = entry_r;
  assign match    = occupied && (entry_r == probe_id);

endmodule

// File: rtl/core/ucnt_timer.sv
// Report period register and millisecond timer of the neighbor counter.
// Depends on ucnt_pkg for widths, reset period and the status struct.
module ucnt_timer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [ucnt_pkg::PeriodW-1:0] cfg_wr_data,
  input  logic                         tick_en,
  output ucnt_pkg::tmr_stat_t          stat
);

  logic [ucnt_pkg::PeriodW-1:0] period_r;
  logic [ucnt_pkg::PeriodW-1:0] timer_r;
  logic [ucnt_pkg::PeriodW-1:0] timer_nxt;
  logic [ucnt_pkg::PeriodW-1:0] timer_inc;
  logic                         elapsed;

  assign timer_inc = timer_r + ucnt_pkg::PeriodW'(1);
  assign elapsed   = (timer_inc >= period_r) || (timer_inc == '0);

  always_comb begin
    timer_nxt = timer_r;
    if (tick_en) begin
      timer_nxt = elapsed ? '0 : timer_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= ucnt_pkg::PeriodReset;
      timer_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      timer_r <= timer_nxt;
    end
  end

  assign stat.report = tick_en && elapsed;

endmodule

// File: rtl/core/unique_id_neighbour_counter.sv
// Top level of the neighbor counter: chain of ID cells, timer and result register.
// Depends on ucnt_pkg, ucnt_cell, ucnt_timer and assert_macros.svh.
//
// The input channel carries one beat per request: an add beat (req_type 0) with a
// 96-bit ID, or a tick beat (req_type 1) standing for one millisecond. Every input
// beat yields exactly one output beat with the entry count and the status flags.
// An add beat is compared against all stored entries at once, one comparator per
// cell, and a new ID is shifted into the head of the chain in the same cycle.
// A tick beat advances the timer; when the period elapses the beat reports whether
// any entry was stored and the table is emptied.
// Each result is registered and appears in the cycle after its beat is accepted.
// One beat is accepted per cycle while in_stall is low.
// While the receiver stalls a pending result, in_stall is raised and the result
// holds; a new beat is taken in the cycle the pending one leaves.
// The user writes the report period through cfg_wr_en/cfg_wr_data only while idle;
// the block has no check. After reset: table empty, timer zero, period 4005 ms.
`include "assert_macros.svh"

module unique_id_neighbour_counter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [ucnt_pkg::PeriodW-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [31:0]                  in_id_word0,
  input  logic [31:0]                  in_id_word1,
  input  logic [31:0]                  in_id_word2,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ucnt_pkg::CntW-1:0]    out_neighbour_count,
  output logic                         out_already_known,
  output logic                         out_dropped_full,
  output logic                         out_report_valid,
  output logic                         out_indicator_on
);

  localparam int N = ucnt_pkg::MaxEntries;

  logic                      accept_in;
  logic                      is_add;
  logic                      hit;
  logic                      full;
  logic                      insert;
  ucnt_pkg::id_t             probe_id;
  ucnt_pkg::id_t             chain [N+1];
  logic [N-1:0]              match;
  ucnt_pkg::tmr_stat_t       tmr_stat;
  logic [ucnt_pkg::CntW-1:0] cnt_r;
  logic [ucnt_pkg::CntW-1:0] cnt_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [ucnt_pkg::CntW-1:0] count_r;
  logic                      known_r;
  logic                      dropped_r;
  logic                      rvalid_r;
  logic                      ind_r;

  assign in_stall  = out_valid_r && out_stall;
  assign accept_in = in_valid && !in_stall;
  assign is_add    = (in_req_type == ucnt_pkg::ReqAdd);

  assign probe_id.w0 = in_id_word0;
  assign probe_id.w1 = in_id_word1;
  assign probe_id.w2 = in_id_word2;
  assign chain[0]    = probe_id;

  assign hit    = |match;
  assign full   = (cnt_r == ucnt_pkg::CntW'(N));
  assign insert = accept_in && is_add && !hit && !full;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ucnt_cell u_cell (
      .clk      (clk),
      .shift_en (insert),
      .occupied (ucnt_pkg::CntW'(i) < cnt_r),
      .prev_id  (chain[i]),
      .probe_id (probe_id),
      .entry_id (chain[i+1]),
      .match    (match[i])
    );
  end

  ucnt_timer u_timer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick_en     (accept_in && (in_req_type == ucnt_pkg::ReqTick)),
    .stat        (tmr_stat)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (insert) begin
      cnt_nxt = cnt_r + ucnt_pkg::CntW'(1);
    end else if (tmr_stat.report) begin
      cnt_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept_in) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      count_r   <= cnt_nxt;
      known_r   <= is_add && hit;
      dropped_r <= is_add && !hit && full;
      rvalid_r  <= tmr_stat.report;
      ind_r     <= tmr_stat.report && (cnt_r != '0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_neighbour_count = count_r;
  assign out_already_known   = known_r;
  assign out_dropped_full    = dropped_r;
  assign out_report_valid    = rvalid_r;
  assign out_indicator_on    = ind_r;

  `ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= ucnt_pkg::CntW'(N))
  `ASSERT_NOW(a_report_clears, clk, rst_n, out_valid && out_report_valid,
              out_neighbour_count == '0 && !out_already_known && !out_dropped_full)
  `ASSERT_NOW(a_flags_excl, clk, rst_n, out_valid && out_already_known,
              !out_dropped_full && !out_indicator_on)
  `ASSERT_NEXT(a_insert_grows, clk, rst_n, insert,
               cnt_r == $past(cnt_r) + ucnt_pkg::CntW'(1))

endmodule

// File: verif/testbench.sv
// Self-checking testbench for unique_id_neighbour_counter: a driver feeds add and tick beats
// from a queue, and a monitor predicts each result and checks the output beats.
// Depends on ucnt_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module testbench;

  localparam int IdlePct = 38;
  localparam int Settle = 3;
  localparam int MaxShown = 50;

  typedef enum logic [1:0] {STEP_BEAT, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t                   kind;
    logic                         req;
    ucnt_pkg::id_t                id;
    logic [ucnt_pkg::PeriodW-1:0] data;
  } step_t;

  typedef struct packed {
    logic [ucnt_pkg::CntW-1:0] count;
    logic                      known;
    logic                      dropped;
    logic                      report;
    logic                      ind;
  } result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [ucnt_pkg::PeriodW-1:0] cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_req_type = ucnt_pkg::ReqAdd;
  logic [31:0]                  in_id_word0 = '0;
  logic [31:0]                  in_id_word1 = '0;
  logic [31:0]                  in_id_word2 = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ucnt_pkg::CntW-1:0]    out_neighbour_count;
  logic                         out_already_known;
  logic                         out_dropped_full;
  logic                         out_report_valid;
  logic                         out_indicator_on;

  step_t   pend_steps[$];
  result_t want_results[$];

  ucnt_pkg::id_t                seen_ids[ucnt_pkg::MaxEntries];
  logic [ucnt_pkg::CntW-1:0]    seen_cnt;
  logic [ucnt_pkg::PeriodW-1:0] ms_timer;
  logic [ucnt_pkg::PeriodW-1:0] period_ms;

  int  quiet = 0;
  int  cyc = 0;
  logic burst;
  int  n_errors = 0;
  int  n_adds = 0;
  int  n_ticks = 0;
  int  n_reports = 0;
  int  n_drops = 0;
  int  n_known = 0;

  assign burst = (cyc >= 3000) && (cyc < 9000);

  unique_id_neighbour_counter u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_id_word0         (in_id_word0),
    .in_id_word1         (in_id_word1),
    .in_id_word2         (in_id_word2),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_neighbour_count (out_neighbour_count),
    .out_already_known   (out_already_known),
    .out_dropped_full    (out_dropped_full),
    .out_report_valid    (out_report_valid),
    .out_indicator_on    (out_indicator_on)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t count_neighbours(logic req, ucnt_pkg::id_t id);
    result_t r;
    r = '0;
    if (req == ucnt_pkg::ReqAdd) begin
      for (int i = 0; i < seen_cnt; i++) begin
        if (seen_ids[i] == id) r.known = 1'b1;
      end
      if (!r.known) begin
        if (seen_cnt < ucnt_pkg::MaxEntries) begin
          seen_ids[seen_cnt] = id;
          seen_cnt = seen_cnt + 1'b1;
        end else begin
          r.dropped = 1'b1;
        end
      end
    end else begin
      ms_timer = ms_timer + 1'b1;
      if (ms_timer >= period_ms || ms_timer == '0) begin
        r.report = 1'b1;
        r.ind = (seen_cnt != '0);
        seen_cnt = '0;
        ms_timer = '0;
      end
    end
    r.count = seen_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_errors < MaxShown) $display("%0t ns: mismatch: %s", $time, msg);
    n_errors++;
  endtask

  function automatic ucnt_pkg::id_t rand_id();
    return {$urandom, $urandom, $urandom};
  endfunction

  task automatic push_add(ucnt_pkg::id_t id);
    step_t s;
    s.kind = STEP_BEAT;
    s.req = ucnt_pkg::ReqAdd;
    s.id = id;
    s.data = '0;
    pend_steps.push_back(s);
  endtask

  task automatic push_tick(int n);
    step_t s;
    s.kind = STEP_BEAT;
    s.req = ucnt_pkg::ReqTick;
    s.data = '0;
    for (int i = 0; i < n; i++) begin
      s.id = rand_id();
      pend_steps.push_back(s);
    end
  endtask

  task automatic push_ctrl(step_kind_t kind, logic [ucnt_pkg::PeriodW-1:0] data);
    step_t s;
    s.kind = kind;
    s.req = ucnt_pkg::ReqAdd;
    s.id = '0;
    s.data = data;
    pend_steps.push_back(s);
  endtask

  task automatic random_phase(int n_items, logic [ucnt_pkg::PeriodW-1:0] period);
    ucnt_pkg::id_t pool[24];
    ucnt_pkg::id_t v;
    int            tick_pct;
    int            r;
    push_ctrl(STEP_CFG, period);
    for (int k = 0; k < 24; k++) begin
      pool[k] = rand_id();
      if (k > 0 && $urandom_range(3) == 0) begin
        pool[k] = pool[$urandom_range(k - 1)];
        pool[k][$urandom_range(95)] ^= 1'b1;
      end
    end
    tick_pct = $urandom_range(40, 5);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < tick_pct) begin
        push_tick(1);
      end else if (r < 80) begin
        push_add(pool[$urandom_range(23)]);
      end else if (r < 90) begin
        push_add(rand_id());
      end else begin
        v = pool[$urandom_range(23)];
        v[$urandom_range(95)] ^= 1'b1;
        push_add(v);
      end
      if (i == n_items / 2 && $urandom_range(1) == 0) push_ctrl(STEP_DRAIN, '0);
    end
  endtask

  always @(posedge clk) begin : drive_p
    step_t nxt;
    logic  go;
    logic  wr;
    go = 1'b0;
    wr = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else if (in_valid && in_stall) begin
      cfg_wr_en <= 1'b0;
    end else begin
      if (pend_steps.size() != 0) begin
        case (pend_steps[0].kind)
          STEP_BEAT: begin
            if (burst || $urandom_range(99) >= IdlePct) begin
              nxt = pend_steps.pop_front();
              go = 1'b1;
              in_req_type <= nxt.req;
              in_id_word0 <= nxt.id.w0;
              in_id_word1 <= nxt.id.w1;
              in_id_word2 <= nxt.id.w2;
            end
          end
          STEP_CFG: begin
            if (quiet >= Settle && !in_valid && !cfg_wr_en) begin
              nxt = pend_steps.pop_front();
              wr = 1'b1;
              cfg_wr_data <= nxt.data;
            end
          end
          default: begin
            if (quiet >= Settle && !in_valid) nxt = pend_steps.pop_front();
          end
        endcase
      end
      in_valid <= go;
      cfg_wr_en <= wr;
    end
  end

  always @(posedge clk) begin : watch_p
    result_t       got;
    result_t       want;
    ucnt_pkg::id_t id;
    if (!rst_n) begin
      seen_cnt = '0;
      ms_timer = '0;
      period_ms = ucnt_pkg::PeriodReset;
      quiet <= 0;
      out_stall <= 1'b0;
    end else begin
      if (cfg_wr_en) period_ms = cfg_wr_data;
      if (out_valid && !out_stall) begin
        got = {out_neighbour_count, out_already_known, out_dropped_full,
               out_report_valid, out_indicator_on};
        if (want_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = want_results.pop_front();
          if (got.count !== want.count)
            report_mismatch($sformatf("neighbour_count %0d, expected %0d", got.count, want.count));
          if (got.known !== want.known)
            report_mismatch($sformatf("already_known %b, expected %b", got.known, want.known));
          if (got.dropped !== want.dropped)
            report_mismatch($sformatf("dropped_full %b, expected %b", got.dropped, want.dropped));
          if (got.report !== want.report)
            report_mismatch($sformatf("report_valid %b, expected %b", got.report, want.report));
          if (got.ind !== want.ind)
            report_mismatch($sformatf("indicator_on %b, expected %b", got.ind, want.ind));
          if (want.report) n_reports++;
          if (want.dropped) n_drops++;
          if (want.known) n_known++;
        end
      end
      if (in_valid && !in_stall) begin
        id = {in_id_word0, in_id_word1, in_id_word2};
        if (in_req_type == ucnt_pkg::ReqTick) n_ticks++;
        else n_adds++;
        want_results.push_back(count_neighbours(in_req_type, id));
      end
      quiet <= (want_results.size() == 0 && !(in_valid && !in_stall)) ? quiet + 1 : 0;
      out_stall <= !burst && ($urandom_range(99) < IdlePct);
    end
    cyc <= cyc + 1;
  end

  initial begin : stim_p
    ucnt_pkg::id_t ones;
    ucnt_pkg::id_t v;
    ones = '1;

    // Duplicates, single-word differences, a full table and a tick with live ID words.
    push_add('0);
    push_add('0);
    push_add(ones);
    v = ones; v.w0 = '0; push_add(v);
    v = ones; v.w1 = '0; push_add(v);
    v = ones; v.w2 = '0; push_add(v);
    push_add(ones);
    push_tick(1);
    for (int i = 0; i < 11; i++) push_add(rand_id());
    push_add(rand_id());
    push_add('0);
    push_tick(1);
    // The reset period does not report within the first few dozen ticks.
    push_tick(40);
    push_add(rand_id());

    // A period of zero reports on every tick.
    push_ctrl(STEP_CFG, 16'd0);
    push_tick(2);
    push_add(ones);
    push_tick(1);
    push_ctrl(STEP_CFG, 16'd1);
    push_tick(1);
    push_add('0);
    push_tick(1);

    // Lowering the period below the running timer reports on the next tick.
    push_ctrl(STEP_CFG, 16'd10);
    push_add(ones);
    push_tick(6);
    push_ctrl(STEP_CFG, 16'd3);
    push_tick(2);

    push_ctrl(STEP_CFG, 16'hFFFF);
    push_tick(20);
    push_add(rand_id());
    push_add(rand_id());
    push_ctrl(STEP_DRAIN, '0);

    random_phase(150, 16'd0);
    random_phase(150, 16'd1);
    random_phase(150, 16'd2);
    random_phase(150, 16'hFFFF);
    random_phase(150, 16'($urandom));
    for (int p = 0; p < 7; p++) random_phase(150, 16'($urandom_range(40, 3)));

    wait (rst_n);
    wait (pend_steps.size() == 0);
    @(posedge clk);
    while (!(quiet >= 8 && !in_valid)) @(posedge clk);
    $display("run covered %0d add beats and %0d tick beats", n_adds, n_ticks);
    $display("%0d reports, %0d known IDs, %0d IDs dropped on a full table",
             n_reports, n_known, n_drops);
    if (n_errors == 0 && want_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still expected", want_results.size());
    $display("testbench: errors");
    $finish;
  end

endmodule

// File: unique_id_neighbour_counter.f
+incdir+rtl/core
rtl/core/ucnt_pkg.sv
rtl/core/ucnt_cell.sv
rtl/core/ucnt_timer.sv
rtl/core/unique_id_neighbour_counter.sv
verif/testbench.sv
